// File: rtl/lstt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lstt_pkg
// Shared types, codes and helpers of the latency statistics and trace table.
// ----------------------------------------------------------------------------
package lstt_pkg;

	localparam int DATA_W = 64;
	localparam int OUT_IDX_W = 3;
	// number of return addresses folded into the path hash (one to four)
	localparam int PATH_DEPTH = 4;
	localparam logic [DATA_W-1:0] ALL_ONES = '1;

	typedef enum logic [1:0] {
		KIND_SAMPLE = 2'd0,
		KIND_CLEAR  = 2'd1,
		KIND_READ   = 2'd2,
		KIND_NOP    = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_HASH,
		ST_LAUNCH,
		ST_SCAN,
		ST_DONE
	} st_t;

	// search packet that walks the slot chain
	typedef struct packed {
		logic              valid;
		logic              hit;
		logic [DATA_W-1:0] hash;
		logic [DATA_W-1:0] min_hits;
		logic [DATA_W-1:0] hit_hits;
	} pkt_t;

	// slot update broadcast to every cell
	typedef struct packed {
		logic              wr;
		logic              clr;
		logic              hit;
		logic [DATA_W-1:0] hash;
	} upd_t;

	function automatic logic [DATA_W-1:0] sat_inc(input logic [DATA_W-1:0] x);
		return (x == ALL_ONES) ? x : x + DATA_W'(1);
	endfunction

endpackage

// File: rtl/lstt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lstt_cell
// One trace slot: holds hash and hit count, checks the passing search packet
// against its slot and passes the packet on to the next cell through a register.
// ----------------------------------------------------------------------------
module lstt_cell
	import lstt_pkg::*;
#(
	parameter int IDX_W = 3,
	parameter int CELL_ID = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  pkt_t             left_pkt,
	input  logic [IDX_W-1:0] left_idx,
	output pkt_t             right_pkt,
	output logic [IDX_W-1:0] right_idx,
	input  upd_t             upd,
	input  logic [IDX_W-1:0] upd_idx,
	output logic [DATA_W-1:0] hits,
	output logic [DATA_W-1:0] hash
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_ID);

	logic [DATA_W-1:0] hits_q;
	logic [DATA_W-1:0] hash_q;
	logic              valid_q;
	pkt_t              pkt_q;
	logic [IDX_W-1:0]  idx_q;
	pkt_t              nxt_pkt;
	logic [IDX_W-1:0]  nxt_idx;

	always_comb begin
		nxt_pkt = left_pkt;
		nxt_idx = left_idx;
		if (!left_pkt.hit) begin
			if (hits_q != '0 && hash_q == left_pkt.hash) begin
				nxt_pkt.hit = 1'b1;
				nxt_pkt.hit_hits = hits_q;
				nxt_idx = MY_IDX;
			end else if (hits_q < left_pkt.min_hits) begin
				nxt_pkt.min_hits = hits_q;
				nxt_idx = MY_IDX;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= left_pkt.valid;
		end
	end

	always_ff @(posedge clk) begin
		pkt_q <= nxt_pkt;
		idx_q <= nxt_idx;
	end

	always_comb begin
		right_pkt = pkt_q;
		right_pkt.valid = valid_q;
	end
	assign right_idx = idx_q;

	// slot contents
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hits_q <= '0;
			hash_q <= '0;
		end else if (upd.clr) begin
			hits_q <= '0;
			hash_q <= '0;
		end else if (upd.wr && upd_idx == MY_IDX) begin
			if (upd.hit) begin
				hits_q <= sat_inc(hits_q);
			end else begin
				hits_q <= DATA_W'(1);
				hash_q <= upd.hash;
			end
		end
	end

	assign hits = hits_q;
	assign hash = hash_q;

endmodule

// File: rtl/latency_stats_with_trace_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// latency_stats_with_trace_table
// Interval latency statistics with a least-frequently-used trace slot table.
// ----------------------------------------------------------------------------
// Takes one event item at a time and returns one result item per event.
// A sample item passes through the prep and hash states, which form the
// interval length and path hash; then a search packet walks the chain of
// slot cells one cell per cycle looking for a matching hash and the first
// least-hit slot, and the done state writes the slot and loads the result
// register. Clear, read and no-operation items go from the prep state
// straight to the done state. The result register lets the next item be
// accepted while the previous result still waits for out_ready.
module latency_stats_with_trace_table
	import lstt_pkg::*;
#(
	parameter int TRACE_SLOTS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           kind,
	input  logic [DATA_W-1:0]    start_time,
	input  logic [DATA_W-1:0]    end_time,
	input  logic                 no_switch,
	input  logic [DATA_W-1:0]    ret_addr_0,
	input  logic [DATA_W-1:0]    ret_addr_1,
	input  logic [DATA_W-1:0]    ret_addr_2,
	input  logic [DATA_W-1:0]    ret_addr_3,
	input  logic [2:0]           slot_select,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [DATA_W-1:0]    event_count,
	output logic [DATA_W-1:0]    total_time,
	output logic [DATA_W-1:0]    max_time,
	output logic [DATA_W-1:0]    ns_count,
	output logic [DATA_W-1:0]    ns_total,
	output logic [DATA_W-1:0]    ns_max,
	output logic [OUT_IDX_W-1:0] slot_index,
	output logic [DATA_W-1:0]    slot_hits,
	output logic [DATA_W-1:0]    slot_hash,
	output logic                 was_hit
);

	localparam int IDX_W = (TRACE_SLOTS > 1) ? $clog2(TRACE_SLOTS) : 1;

	st_t state_q, state_d;
	logic launch;
	logic done_fire;
	logic accept;

	kind_t             kind_q;
	logic [DATA_W-1:0] start_q, end_q;
	logic              no_switch_q;
	logic [DATA_W-1:0] addr0_q, addr1_q, addr2_q, addr3_q;
	logic [2:0]        sel_q;

	logic [DATA_W-1:0] delta_q, pair0_q, pair1_q, hash_q;

	logic [DATA_W-1:0] count_q, total_q, max_q;
	logic [DATA_W-1:0] ns_count_q, ns_total_q, ns_max_q;

	pkt_t              found_q;
	logic [IDX_W-1:0]  found_idx_q;

	pkt_t              pkt_chain [TRACE_SLOTS+1];
	logic [IDX_W-1:0]  idx_chain [TRACE_SLOTS+1];
	logic [DATA_W-1:0] cell_hits [TRACE_SLOTS];
	logic [DATA_W-1:0] cell_hash [TRACE_SLOTS];
	upd_t              upd;
	logic [IDX_W-1:0]  upd_idx;

	logic              out_valid_q;
	logic [DATA_W-1:0] event_count_q, total_time_q, max_time_q;
	logic [DATA_W-1:0] ns_count_q2, ns_total_q2, ns_max_q2;
	logic [OUT_IDX_W-1:0] slot_index_q;
	logic [DATA_W-1:0] slot_hits_q, slot_hash_q;
	logic              was_hit_q;

	logic              sel_in_range;
	logic [IDX_W-1:0]  sel_idx;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		launch = 1'b0;
		done_fire = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				state_d = (kind_q == KIND_SAMPLE) ? ST_HASH : ST_DONE;
			end
			ST_HASH: begin
				state_d = ST_LAUNCH;
			end
			ST_LAUNCH: begin
				launch = 1'b1;
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (pkt_chain[TRACE_SLOTS].valid) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					done_fire = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign accept = in_valid && in_ready;

	// input capture
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind_t'(kind);
			start_q <= start_time;
			end_q <= end_time;
			no_switch_q <= no_switch;
			addr0_q <= ret_addr_0;
			addr1_q <= ret_addr_1;
			addr2_q <= ret_addr_2;
			addr3_q <= ret_addr_3;
			sel_q <= slot_select;
		end
	end

	// interval length and path hash
	always_ff @(posedge clk) begin
		if (state_q == ST_PREP) begin
			delta_q <= end_q - start_q;
			pair0_q <= ((PATH_DEPTH >= 1) ? addr0_q : '0) + ((PATH_DEPTH >= 2) ? addr1_q : '0);
			pair1_q <= ((PATH_DEPTH >= 3) ? addr2_q : '0) + ((PATH_DEPTH >= 4) ? addr3_q : '0);
		end
		if (state_q == ST_HASH) begin
			hash_q <= pair0_q + pair1_q;
		end
	end

	// statistics
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			total_q <= '0;
			max_q <= '0;
			ns_count_q <= '0;
			ns_total_q <= '0;
			ns_max_q <= '0;
		end else if (state_q == ST_HASH) begin
			count_q <= count_q + DATA_W'(1);
			total_q <= total_q + delta_q;
			if (delta_q > max_q) begin
				max_q <= delta_q;
			end
			if (no_switch_q) begin
				ns_count_q <= ns_count_q + DATA_W'(1);
				ns_total_q <= ns_total_q + delta_q;
				if (delta_q > ns_max_q) begin
					ns_max_q <= delta_q;
				end
			end
		end else if (done_fire && kind_q == KIND_CLEAR) begin
			count_q <= '0;
			total_q <= '0;
			max_q <= '0;
			ns_count_q <= '0;
			ns_total_q <= '0;
			ns_max_q <= '0;
		end
	end

	// search packet entering the chain
	always_comb begin
		pkt_chain[0].valid = launch;
		pkt_chain[0].hit = 1'b0;
		pkt_chain[0].hash = hash_q;
		pkt_chain[0].min_hits = ALL_ONES;
		pkt_chain[0].hit_hits = '0;
		idx_chain[0] = '0;
	end

	assign upd.wr = done_fire && kind_q == KIND_SAMPLE;
	assign upd.clr = done_fire && kind_q == KIND_CLEAR;
	assign upd.hit = found_q.hit;
	assign upd.hash = hash_q;
	assign upd_idx = found_idx_q;

	for (genvar i = 0; i < TRACE_SLOTS; i++) begin : g_cell
		lstt_cell #(
			.IDX_W   (IDX_W),
			.CELL_ID (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.left_pkt  (pkt_chain[i]),
			.left_idx  (idx_chain[i]),
			.right_pkt (pkt_chain[i+1]),
			.right_idx (idx_chain[i+1]),
			.upd       (upd),
			.upd_idx   (upd_idx),
			.hits      (cell_hits[i]),
			.hash      (cell_hash[i])
		);
	end

	// packet leaving the last cell
	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN && pkt_chain[TRACE_SLOTS].valid) begin
			found_q <= pkt_chain[TRACE_SLOTS];
			found_idx_q <= idx_chain[TRACE_SLOTS];
		end
	end

	assign sel_in_range = 32'(sel_q) < TRACE_SLOTS;
	assign sel_idx = IDX_W'(sel_q);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_fire) begin
			event_count_q <= count_q;
			total_time_q <= total_q;
			max_time_q <= max_q;
			ns_count_q2 <= ns_count_q;
			ns_total_q2 <= ns_total_q;
			ns_max_q2 <= ns_max_q;
			slot_index_q <= '0;
			slot_hits_q <= '0;
			slot_hash_q <= '0;
			was_hit_q <= 1'b0;
			case (kind_q)
				KIND_SAMPLE: begin
					slot_index_q <= OUT_IDX_W'(found_idx_q);
					slot_hits_q <= found_q.hit ? sat_inc(found_q.hit_hits) : DATA_W'(1);
					slot_hash_q <= hash_q;
					was_hit_q <= found_q.hit;
				end
				KIND_CLEAR: begin
					event_count_q <= '0;
					total_time_q <= '0;
					max_time_q <= '0;
					ns_count_q2 <= '0;
					ns_total_q2 <= '0;
					ns_max_q2 <= '0;
				end
				KIND_READ: begin
					slot_index_q <= sel_q;
					if (sel_in_range) begin
						slot_hits_q <= cell_hits[sel_idx];
						slot_hash_q <= cell_hash[sel_idx];
					end
				end
				default: begin
					slot_index_q <= '0;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign event_count = event_count_q;
	assign total_time = total_time_q;
	assign max_time = max_time_q;
	assign ns_count = ns_count_q2;
	assign ns_total = ns_total_q2;
	assign ns_max = ns_max_q2;
	assign slot_index = slot_index_q;
	assign slot_hits = slot_hits_q;
	assign slot_hash = slot_hash_q;
	assign was_hit = was_hit_q;

`ifndef SYNTH
	// one item in flight at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("item accepted while another is in flight");

	// a matched slot always has hits
	a_hit_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && was_hit |-> slot_hits != '0)
		else $error("hit reported on an empty slot");

	// the search packet leaves the chain only while the sequencer waits for it
	a_scan_end: assert property (@(posedge clk) disable iff (!arst_n)
		pkt_chain[TRACE_SLOTS].valid |-> state_q == ST_SCAN)
		else $error("search packet left the chain outside the scan");
`endif

endmodule
